// ===== design/hmsa_pkg.sv =====
// hmsa_pkg: shared types and constants of the histogram / mean / std block
// no dependencies
package hmsa_pkg;

  localparam int MAX_BINS    = 64;
  localparam int BIN_AW      = $clog2(MAX_BINS);
  localparam int COUNT_WIDTH = 24;
  localparam int BIN_W       = 24;

  // serial divider: dividend bits, divisor bits
  localparam int DIV_NW = 72;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = $clog2(DIV_NW);

  // serial square root: radicand bits, root bits
  localparam int SQ_W  = 48;
  localparam int SQ_RW = SQ_W / 2;
  localparam int SQ_CW = $clog2(SQ_RW);

  localparam logic [1:0] CFG_MIN  = 2'd0;
  localparam logic [1:0] CFG_MAX  = 2'd1;
  localparam logic [1:0] CFG_BINS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_START, ST_DIV, ST_MEM, ST_BUMP, ST_SQRT, ST_DONE
  } hmsa_state_t;

  typedef enum logic [1:0] {
    BIN_UNDER, BIN_REG, BIN_OVER
  } hmsa_class_t;

endpackage

// ===== design/hmsa_div.sv =====
// hmsa_div: restoring divider, one quotient bit per cycle
// depends on hmsa_pkg
module hmsa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hmsa_pkg::DIV_NW-1:0]  dividend,
  input  logic [hmsa_pkg::DIV_DW-1:0]  divisor,
  output logic                         done,
  output logic [hmsa_pkg::DIV_NW-1:0]  quotient
);
  import hmsa_pkg::*;

  logic [DIV_NW-1:0] work;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsor;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   rem_sh;
  logic              qbit;
  logic [DIV_DW-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, work[DIV_NW-1]};
    qbit     = (rem_sh >= {1'b0, dsor});
    rem_next = qbit ? DIV_DW'(rem_sh - {1'b0, dsor}) : DIV_DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dsor <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[DIV_NW-2:0], qbit};
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

// ===== design/hmsa_sqrt.sv =====
// hmsa_sqrt: integer square root, two radicand bits per cycle
// depends on hmsa_pkg
module hmsa_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hmsa_pkg::SQ_W-1:0]   radicand,
  output logic                        done,
  output logic [hmsa_pkg::SQ_RW-1:0]  root
);
  import hmsa_pkg::*;

  logic [SQ_W-1:0]  val;
  logic [SQ_RW+1:0] rem;
  logic [SQ_CW-1:0] cnt;
  logic             busy;
  logic [SQ_RW+3:0] rem_sh;
  logic [SQ_RW+3:0] trial;
  logic             take;

  always_comb begin
    rem_sh = {rem, val[SQ_W-1:SQ_W-2]};
    trial  = {2'b00, root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQ_CW'(SQ_RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[SQ_W-3:0], 2'b00};
      rem  <= take ? (SQ_RW+2)'(rem_sh - trial) : (SQ_RW+2)'(rem_sh);
      root <= {root[SQ_RW-2:0], take};
    end
  end

endmodule

// ===== design/histogram_mean_std_accumulator_unit.sv =====
// histogram_mean_std_accumulator_unit: binned histogram with running mean and std
// steps from input accept to result valid: latch and accumulate, the serial dividers
//   (mean, mean square, bin index side by side), bin read and update, square root, output load
// one word is processed at a time; the next word is taken while a result waits
// reset (rst, synchronous): registers to 0 / 1000 / 64, accumulators and bin valid bits
//   cleared at once, no clearing pass
module histogram_mean_std_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [6:0]                          bin_index,
  output logic [hmsa_pkg::BIN_W-1:0]          bin_total,
  output logic [hmsa_pkg::COUNT_WIDTH-1:0]    sample_count,
  output logic signed [23:0]                  mean_fixed,
  output logic [23:0]                         std_fixed,
  output logic                                saturated
);
  import hmsa_pkg::*;

  // configuration
  logic signed [15:0] min_value;
  logic signed [15:0] max_value;
  logic [6:0]         bucket_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value    <= 16'sd0;
      max_value    <= 16'sd1000;
      bucket_count <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN:  min_value    <= cfg_data;
        CFG_MAX:  max_value    <= cfg_data;
        CFG_BINS: bucket_count <= cfg_data[6:0];
        default:  ;
      endcase
    end
  end

  // sequencer
  hmsa_state_t state, state_next;
  logic div_start, sq_start;
  logic div_done, sq_done;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    sq_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_ACC;
      end
      ST_ACC:   state_next = ST_START;
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV:   if (div_done) state_next = ST_MEM;
      ST_MEM:   state_next = ST_BUMP;
      ST_BUMP: begin
        sq_start   = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT:  if (sq_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // accumulators
  logic [COUNT_WIDTH-1:0] count;
  logic signed [39:0]     sum;
  logic [54:0]            sumsq;
  logic [BIN_W-1:0]       below_count;
  logic [BIN_W-1:0]       above_count;

  // per word working registers
  logic signed [15:0] sample_r;
  logic [31:0]        sq_r;
  logic               hold_r;
  hmsa_class_t        cls_r;
  logic [21:0]        prod_r;
  logic [15:0]        span_r;
  logic [6:0]         nb_r;
  logic               mean_neg_r;
  logic [23:0]        mean_mag_r;
  logic [SQ_W-1:0]    q_r;
  logic [SQ_W-1:0]    msq_r;
  logic [BIN_AW-1:0]  k_r;
  logic [BIN_W-1:0]   rd_data;
  logic [BIN_W-1:0]   total_r;
  logic [23:0]        std_r;

  // bin store: memory plus one valid bit per entry, cleared by reset
  logic [BIN_W-1:0]    bin_mem [MAX_BINS];
  logic [MAX_BINS-1:0] bin_valid;

  // combinational helpers
  logic               hold;
  logic [6:0]         nb_clamp;
  logic signed [16:0] off_w;
  logic signed [16:0] span_w;
  logic [39:0]        sum_mag;
  logic [BIN_W-1:0]   cur_total;
  logic [BIN_W-1:0]   new_total;
  logic [SQ_W-1:0]    dev;

  always_comb begin
    hold     = (count == {COUNT_WIDTH{1'b1}});
    if (bucket_count == 7'd0)                    nb_clamp = 7'd1;
    else if (bucket_count > 7'(MAX_BINS))        nb_clamp = 7'(MAX_BINS);
    else                                         nb_clamp = bucket_count;
    off_w    = 17'(sample_r) - 17'(min_value);
    span_w   = 17'(max_value) - 17'(min_value);
    sum_mag  = sum[39] ? 40'(-sum) : 40'(sum);
    case (cls_r)
      BIN_UNDER: cur_total = below_count;
      BIN_OVER:  cur_total = above_count;
      default:   cur_total = bin_valid[k_r] ? rd_data : '0;
    endcase
    // bins stop at full scale; no change at all once the count holds
    new_total = (!hold_r && cur_total != {BIN_W{1'b1}}) ? cur_total + 1'b1 : cur_total;
    dev       = (q_r >= msq_r) ? q_r - msq_r : msq_r - q_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      sum         <= '0;
      sumsq       <= '0;
      below_count <= '0;
      above_count <= '0;
      bin_valid   <= '0;
    end else begin
      if (state == ST_ACC && !hold) begin
        count <= count + 1'b1;
        sum   <= sum + 40'(sample_r);
        sumsq <= sumsq + 55'(sq_r);
      end
      if (state == ST_BUMP) begin
        case (cls_r)
          BIN_UNDER: below_count <= new_total;
          BIN_OVER:  above_count <= new_total;
          default:   if (!hold_r) bin_valid[k_r] <= 1'b1;
        endcase
      end
    end
  end

  // bin memory: registered read, single write
  always_ff @(posedge clk) begin
    if (state == ST_MEM) rd_data <= bin_mem[k_r];
    if (state == ST_BUMP && cls_r == BIN_REG && !hold_r) bin_mem[k_r] <= new_total;
  end

  // serial dividers: mean, mean square, bin index
  logic [DIV_NW-1:0] mean_quo, msq_quo, bin_quo;
  logic              mean_done, msq_done, bin_done;

  assign div_done = mean_done && msq_done && bin_done;

  hmsa_div u_div_mean (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({24'd0, sum_mag, 8'd0}),
    .divisor  (count),
    .done     (mean_done),
    .quotient (mean_quo)
  );

  hmsa_div u_div_msq (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({1'b0, sumsq, 16'd0}),
    .divisor  (count),
    .done     (msq_done),
    .quotient (msq_quo)
  );

  // dividend is garbage when the word misses the regular bins; result unused then
  hmsa_div u_div_bin (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({50'd0, prod_r}),
    .divisor  ({8'd0, span_r}),
    .done     (bin_done),
    .quotient (bin_quo)
  );

  hmsa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (dev),
    .done     (sq_done),
    .root     (std_r)
  );

  // datapath registers, loaded per state
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sample_r <= sample;
      sq_r     <= 32'(sample * sample);
    end
    if (state == ST_ACC) begin
      hold_r <= hold;
      nb_r   <= nb_clamp;
      span_r <= span_w[15:0];
      prod_r <= 22'(off_w[15:0] * nb_clamp);
      if (sample_r < min_value)       cls_r <= BIN_UNDER;
      else if (sample_r >= max_value) cls_r <= BIN_OVER;
      else                            cls_r <= BIN_REG;
    end
    if (state == ST_START) mean_neg_r <= sum[39];
    if (state == ST_DIV && div_done) begin
      mean_mag_r <= mean_quo[23:0];
      q_r        <= msq_quo[SQ_W-1:0];
      // clamp to last bin in use
      if (bin_quo[6:0] >= nb_r) k_r <= BIN_AW'(nb_r - 7'd1);
      else                      k_r <= bin_quo[BIN_AW-1:0];
    end
    if (state == ST_MEM) msq_r <= SQ_W'(mean_mag_r * mean_mag_r);
    if (state == ST_BUMP) total_r <= new_total;
  end

  // output register, parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      case (cls_r)
        BIN_UNDER: bin_index <= 7'd0;
        BIN_OVER:  bin_index <= 7'(MAX_BINS + 1);
        default:   bin_index <= 7'(k_r) + 7'd1;
      endcase
      bin_total    <= total_r;
      sample_count <= count;
      mean_fixed   <= mean_neg_r ? 24'(-mean_mag_r) : mean_mag_r;
      std_fixed    <= std_r;
      saturated    <= (count == {COUNT_WIDTH{1'b1}});
    end
  end

endmodule

// ===== design/hmsa_checker.sv =====
// hmsa_checker: port level checks of the histogram unit, bound to the top level
// depends on hmsa_pkg
module hmsa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [6:0]                         bin_index,
  input logic [hmsa_pkg::BIN_W-1:0]         bin_total,
  input logic [hmsa_pkg::COUNT_WIDTH-1:0]   sample_count,
  input logic                               saturated
);
  import hmsa_pkg::*;

  // the bin index and bin total of a stalled word hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_index) && $stable(bin_total))
    else $error("result word changed while stalled");

  a_sat_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> sample_count == {COUNT_WIDTH{1'b1}})
    else $error("saturated without full count");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_index <= 7'(MAX_BINS + 1))
    else $error("bin index out of range");

  a_nonzero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count != '0 && bin_total <= BIN_W'(sample_count))
    else $error("bin total exceeds sample count");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind histogram_mean_std_accumulator_unit hmsa_checker u_hmsa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .bin_index    (bin_index),
  .bin_total    (bin_total),
  .sample_count (sample_count),
  .saturated    (saturated)
);
